/* hw/rtl/eds_pkg.sv */
package eds_pkg;

   // Number of encoders served; the select field is one bit wide.
   localparam int NUM_ENC = 2;

   // Field widths.
   localparam int COEFF_W = 32;
   localparam int CNT_W   = 16;
   localparam int TIME_W  = 16;
   localparam int TOT_W   = 32;
   localparam int DIST_W  = 64;
   localparam int DDIST_W = 48;
   localparam int SPEED_W = 48;

   // Serial multiplier: one coefficient bit per cycle.
   localparam int MUL_STEPS = COEFF_W;
   localparam int SCALE_W   = 20;
   localparam logic [SCALE_W-1:0] MICROS_PER_SEC = 20'd1000000;
   localparam int SP_MC_W = CNT_W + SCALE_W;
   localparam int SP_P_W  = SP_MC_W + COEFF_W;

   // Serial divider: dividend is (|delta distance| * 10^6) / 256.
   localparam int DIV_NUM_W = 58;
   localparam int DIV_QUO_W = SPEED_W;
   localparam int DIV_DEN_W = TIME_W;
   localparam int DIV_SHIFT = 8;

   localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [SPEED_W-1:0] SPEED_NEG_MAX = 48'h8000_0000_0000;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_0   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COEFF_1   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_INVERT_0  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_INVERT_1  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_ZERO_POS  = 3'd4;

   localparam logic [COEFF_W-1:0] COEFF_0_RESET  = 32'sd1345010;
   localparam logic [COEFF_W-1:0] COEFF_1_RESET  = -32'sd1375463;
   localparam logic [CNT_W-1:0]   ZERO_POS_RESET = 16'd32768;

   // Item kinds.
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_CLEAR = 1'b1;

   typedef struct packed {
      logic done;
      logic overflow;
   } div_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PREP = 5'b00010,
      ST_MUL  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

endpackage

/* hw/rtl/encoder_distance_speed.sv */
// Position and speed for two wheel encoders.
// Request channel (req_): one word per item. tuser carries the item kind
// (read or clear) and the encoder number; tdata carries the sampled counter
// and the microsecond timestamp. A read gives one response word; a clear
// only zeroes that encoder's running count and gives none.
// Response channel (rsp_): tuser carries the encoder number, tdata carries
// distance, delta distance and speed, all Q24 or Q16 fixed point.
// Configuration (csr_): a write with csr_wr_en high stores csr_wdata into the
// register at csr_addr; unknown addresses are ignored. Write only when idle.
// Sequence: a read passes through a setup step, the bit-serial multiplier, a
// divider load step, the bit-serial divider and the done state before its
// result enters the output register; when the quotient cannot fit in 48 bits
// the divider ends at its load step. One read is in work at a time, so a read
// holds the block until its result enters the output register. A clear item
// is done at acceptance and leaves the block idle.
// The response sits in an output register, so a new item is accepted while
// the receiver stalls; only the next read's result waits for that register.
// Synchronous reset restores the register defaults, zeroes both running
// counts and timestamps, and drops any pending response.
module encoder_distance_speed (
   input  logic         clock,
   input  logic         reset,
   // Request channel.
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [15:0] counter_value, [31:16] time_us
   input  logic [1:0]   req_tuser,   // [0] kind, [1] encoder_select
   // Response channel.
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // [63:0] distance, [111:64] delta distance,
                                     // [159:112] speed
   output logic [0:0]   rsp_tuser,   // [0] encoder_id
   // Configuration port.
   input  logic                              csr_wr_en,
   input  logic [eds_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [eds_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int COEFF_W = eds_pkg::COEFF_W;
   localparam int CNT_W   = eds_pkg::CNT_W;
   localparam int TIME_W  = eds_pkg::TIME_W;
   localparam int TOT_W   = eds_pkg::TOT_W;
   localparam int DIST_W  = eds_pkg::DIST_W;
   localparam int DDIST_W = eds_pkg::DDIST_W;
   localparam int SPEED_W = eds_pkg::SPEED_W;
   localparam int SP_MC_W = eds_pkg::SP_MC_W;
   localparam int SP_P_W  = eds_pkg::SP_P_W;
   localparam int MSTEP_W = $clog2(eds_pkg::MUL_STEPS);

   // Configuration registers.
   logic [COEFF_W-1:0] coeff_0_ff;
   logic [COEFF_W-1:0] coeff_1_ff;
   logic               invert_0_ff;
   logic               invert_1_ff;
   logic [CNT_W-1:0]   zero_pos_ff;

   // Per-encoder state.
   logic [TIME_W-1:0]  last_time_ff   [eds_pkg::NUM_ENC];
   logic [TOT_W-1:0]   total_count_ff [eds_pkg::NUM_ENC];

   eds_pkg::state_type state_ff, state_in;

   // Item registers.
   logic               enc_ff;
   logic [TOT_W-1:0]   tot_ff;
   logic [CNT_W-1:0]   delta_ff;
   logic [COEFF_W-1:0] coeff_ff;
   logic               inv_ff;
   logic [TIME_W-1:0]  dt_ff;
   logic               sd_ff;
   logic               sdd_ff;

   // Serial multiplier registers: three products share the coefficient bits.
   logic [TOT_W-1:0]   mc_tot_ff;
   logic [CNT_W-1:0]   mc_dd_ff;
   logic [SP_MC_W-1:0] mc_sp_ff;
   logic [TOT_W-1:0]   hi_tot_ff;
   logic [CNT_W-1:0]   hi_dd_ff;
   logic [SP_MC_W-1:0] hi_sp_ff;
   logic [COEFF_W-1:0] lo_tot_ff;
   logic [COEFF_W-1:0] lo_dd_ff;
   logic [COEFF_W-1:0] lo_sp_ff;
   logic [MSTEP_W-1:0] mstep_ff;
   logic               div_start_ff;

   // Output register.
   logic               rsp_valid_ff;
   logic               rsp_id_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic [DDIST_W-1:0] rsp_ddist_ff;
   logic [SPEED_W-1:0] rsp_speed_ff;

   logic               req_fire;
   logic               req_kind;
   logic               req_sel;
   logic [CNT_W-1:0]   req_cnt;
   logic [TIME_W-1:0]  req_now;
   logic               enc_ok;
   logic [CNT_W-1:0]   delta_in;
   logic [TOT_W-1:0]   tot_in;
   logic [TIME_W-1:0]  elapsed;
   logic [TIME_W-1:0]  dt_in;

   logic [TOT_W-1:0]   tot_abs;
   logic [COEFF_W-1:0] coeff_abs;
   logic [CNT_W-1:0]   delta_abs;
   logic [SP_MC_W-1:0] sp_mc_in;

   logic               mbit;
   logic [TOT_W:0]     sum_tot;
   logic [CNT_W:0]     sum_dd;
   logic [SP_MC_W:0]   sum_sp;
   logic               mul_last;

   logic [DIST_W-1:0]  p_tot;
   logic [DDIST_W-1:0] p_dd;
   logic [SP_P_W-1:0]  p_sp;
   logic [DIST_W-1:0]  dist_out;
   logic [DDIST_W-1:0] ddist_out;
   logic [SPEED_W-1:0] speed_out;
   logic               speed_sat;
   logic               rsp_load;

   eds_pkg::div_stat_type           div_stat;
   logic [eds_pkg::DIV_QUO_W-1:0]   div_quo;

   // Request decode and the per-encoder update done at acceptance.
   assign req_tready = (state_ff == eds_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_kind   = req_tuser[0];
   assign req_sel    = req_tuser[1];
   assign req_cnt    = req_tdata[CNT_W-1:0];
   assign req_now    = req_tdata[CNT_W+TIME_W-1:CNT_W];
   assign enc_ok     = 32'(req_sel) < 32'(eds_pkg::NUM_ENC);

   assign delta_in = req_cnt - zero_pos_ff;
   assign tot_in   = total_count_ff[req_sel] + {{(TOT_W-CNT_W){delta_in[CNT_W-1]}}, delta_in};
   assign elapsed  = req_now - last_time_ff[req_sel];
   // A zero elapsed time counts as the longest interval the timer can show.
   assign dt_in    = (elapsed == '0) ? '1 : elapsed;

   // Magnitudes for the unsigned serial multiplier; the signs are kept aside.
   assign tot_abs   = tot_ff[TOT_W-1] ? -tot_ff : tot_ff;
   assign coeff_abs = coeff_ff[COEFF_W-1] ? -coeff_ff : coeff_ff;
   assign delta_abs = delta_ff[CNT_W-1] ? -delta_ff : delta_ff;
   assign sp_mc_in  = SP_MC_W'(delta_abs) * SP_MC_W'(eds_pkg::MICROS_PER_SEC);

   // One shift-and-add step: the low coefficient bit selects the multiplicand,
   // and each product shifts right by one bit into its low register.
   assign mbit     = lo_tot_ff[0];
   assign sum_tot  = {1'b0, hi_tot_ff} + (mbit ? {1'b0, mc_tot_ff} : '0);
   assign sum_dd   = {1'b0, hi_dd_ff} + (mbit ? {1'b0, mc_dd_ff} : '0);
   assign sum_sp   = {1'b0, hi_sp_ff} + (mbit ? {1'b0, mc_sp_ff} : '0);
   assign mul_last = (mstep_ff == MSTEP_W'(eds_pkg::MUL_STEPS - 1));

   assign p_tot = {hi_tot_ff, lo_tot_ff};
   assign p_dd  = {hi_dd_ff, lo_dd_ff};
   assign p_sp  = {hi_sp_ff, lo_sp_ff};

   // The speed dividend is |delta distance| * 10^6 / 256, the divisor the
   // elapsed microseconds.
   eds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (p_sp[eds_pkg::DIV_NUM_W+eds_pkg::DIV_SHIFT-1:eds_pkg::DIV_SHIFT]),
      .divisor  (dt_ff),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Results get their signs back here. A negative speed saturates to a value
   // one step further from zero than a positive one does.
   assign dist_out  = sd_ff ? -p_tot : p_tot;
   assign ddist_out = sdd_ff ? -p_dd : p_dd;
   assign speed_sat = div_stat.overflow || div_quo[SPEED_W-1];

   always_comb begin
      if (sdd_ff) begin
         speed_out = speed_sat ? eds_pkg::SPEED_NEG_MAX : -div_quo;
      end else begin
         speed_out = speed_sat ? eds_pkg::SPEED_POS_MAX : div_quo;
      end
   end

   assign rsp_load = (state_ff == eds_pkg::ST_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eds_pkg::ST_IDLE: begin
            if (req_fire && enc_ok && (req_kind == eds_pkg::KIND_READ)) begin
               state_in = eds_pkg::ST_PREP;
            end
         end
         eds_pkg::ST_PREP: begin
            state_in = eds_pkg::ST_MUL;
         end
         eds_pkg::ST_MUL: begin
            if (mul_last) begin
               state_in = eds_pkg::ST_DIV;
            end
         end
         eds_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = eds_pkg::ST_DONE;
            end
         end
         eds_pkg::ST_DONE: begin
            if (rsp_load) begin
               state_in = eds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = eds_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eds_pkg::ST_IDLE;
         mstep_ff     <= '0;
         div_start_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_start_ff <= (state_ff == eds_pkg::ST_MUL) && mul_last;
         if (state_ff == eds_pkg::ST_PREP) begin
            mstep_ff <= '0;
         end else if (state_ff == eds_pkg::ST_MUL) begin
            mstep_ff <= mstep_ff + 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_0_ff  <= eds_pkg::COEFF_0_RESET;
         coeff_1_ff  <= eds_pkg::COEFF_1_RESET;
         invert_0_ff <= 1'b0;
         invert_1_ff <= 1'b0;
         zero_pos_ff <= eds_pkg::ZERO_POS_RESET;
      end else if (csr_wr_en) begin
         case (csr_addr)
            eds_pkg::REG_COEFF_0:  coeff_0_ff  <= csr_wdata[COEFF_W-1:0];
            eds_pkg::REG_COEFF_1:  coeff_1_ff  <= csr_wdata[COEFF_W-1:0];
            eds_pkg::REG_INVERT_0: invert_0_ff <= csr_wdata[0];
            eds_pkg::REG_INVERT_1: invert_1_ff <= csr_wdata[0];
            eds_pkg::REG_ZERO_POS: zero_pos_ff <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Running counts and timestamps. A clear keeps the timestamp.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < eds_pkg::NUM_ENC; i++) begin
            last_time_ff[i]   <= '0;
            total_count_ff[i] <= '0;
         end
      end else if (req_fire && enc_ok) begin
         if (req_kind == eds_pkg::KIND_CLEAR) begin
            total_count_ff[req_sel] <= '0;
         end else begin
            total_count_ff[req_sel] <= tot_in;
            last_time_ff[req_sel]   <= req_now;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (state_ff == eds_pkg::ST_IDLE) begin
         enc_ff   <= req_sel;
         tot_ff   <= tot_in;
         delta_ff <= delta_in;
         coeff_ff <= req_sel ? coeff_1_ff : coeff_0_ff;
         inv_ff   <= req_sel ? invert_1_ff : invert_0_ff;
         dt_ff    <= dt_in;
      end
      if (state_ff == eds_pkg::ST_PREP) begin
         mc_tot_ff <= tot_abs;
         mc_dd_ff  <= delta_abs;
         mc_sp_ff  <= sp_mc_in;
         hi_tot_ff <= '0;
         hi_dd_ff  <= '0;
         hi_sp_ff  <= '0;
         lo_tot_ff <= coeff_abs;
         lo_dd_ff  <= coeff_abs;
         lo_sp_ff  <= coeff_abs;
         sd_ff     <= tot_ff[TOT_W-1] ^ coeff_ff[COEFF_W-1] ^ inv_ff;
         sdd_ff    <= delta_ff[CNT_W-1] ^ coeff_ff[COEFF_W-1] ^ inv_ff;
      end
      if (state_ff == eds_pkg::ST_MUL) begin
         hi_tot_ff <= sum_tot[TOT_W:1];
         hi_dd_ff  <= sum_dd[CNT_W:1];
         hi_sp_ff  <= sum_sp[SP_MC_W:1];
         lo_tot_ff <= {sum_tot[0], lo_tot_ff[COEFF_W-1:1]};
         lo_dd_ff  <= {sum_dd[0], lo_dd_ff[COEFF_W-1:1]};
         lo_sp_ff  <= {sum_sp[0], lo_sp_ff[COEFF_W-1:1]};
      end
      if (rsp_load) begin
         rsp_id_ff    <= enc_ff;
         rsp_dist_ff  <= dist_out;
         rsp_ddist_ff <= ddist_out;
         rsp_speed_ff <= speed_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_speed_ff, rsp_ddist_ff, rsp_dist_ff};
   assign rsp_tuser  = rsp_id_ff;

endmodule

/* hw/rtl/eds_div.sv */
module eds_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [eds_pkg::DIV_NUM_W-1:0]    dividend,
   input  logic [eds_pkg::DIV_DEN_W-1:0]    divisor,
   output eds_pkg::div_stat_type            stat,
   output logic [eds_pkg::DIV_QUO_W-1:0]    quotient
);

   localparam int NUM_W  = eds_pkg::DIV_NUM_W;
   localparam int QUO_W  = eds_pkg::DIV_QUO_W;
   localparam int DEN_W  = eds_pkg::DIV_DEN_W;
   localparam int STEP_W = $clog2(QUO_W);

   logic [DEN_W-1:0]  rem_ff;
   logic [QUO_W-1:0]  quo_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              ovf_ff;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;
   logic              head_ovf;

   // The quotient fits in QUO_W bits only when the bits above it divide to zero.
   assign head_ovf = DEN_W'(dividend[NUM_W-1:QUO_W]) >= divisor;

   assign trial = {rem_ff, quo_ff[QUO_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ovf_ff  <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            ovf_ff  <= head_ovf;
            busy_ff <= !head_ovf;
            done_ff <= head_ovf;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Restoring division, one quotient bit per cycle; dividend bits shift out
   // of the top of the quotient register as quotient bits enter at the bottom.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DEN_W'(dividend[NUM_W-1:QUO_W]);
         quo_ff <= dividend[QUO_W-1:0];
      end else if (busy_ff) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_ff <= {quo_ff[QUO_W-2:0], fits};
      end
   end

   assign stat.done     = done_ff;
   assign stat.overflow = ovf_ff;
   assign quotient      = quo_ff;

endmodule
